// ===== src/mafl_pkg.sv =====
// Shared constants, lookup tables and the item type for the MPEG audio frame length block.
package mafl_pkg;

    localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

    localparam logic [1:0] VER_25  = 2'b00;
    localparam logic [1:0] VER_RSV = 2'b01;
    localparam logic [1:0] VER_2   = 2'b10;
    localparam logic [1:0] VER_1   = 2'b11;

    localparam logic [1:0] LAY_RSV = 2'b00;
    localparam logic [1:0] LAY_3   = 2'b01;
    localparam logic [1:0] LAY_2   = 2'b10;
    localparam logic [1:0] LAY_1   = 2'b11;

    localparam logic [10:0] SPF_384  = 11'd384;
    localparam logic [10:0] SPF_576  = 11'd576;
    localparam logic [10:0] SPF_1152 = 11'd1152;

    // Numerator scale factors: 12000 for layer I, 125 times samples otherwise.
    localparam logic [17:0] FACTOR_L1   = 18'd12000;
    localparam logic [17:0] FACTOR_576  = 18'd72000;
    localparam logic [17:0] FACTOR_1152 = 18'd144000;

    localparam int NUM_W = 26;
    localparam int QUO_W = 12;
    localparam int REM_W = 16;
    localparam int OUT_W = 48;

    localparam logic [8:0] KBPS_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
        9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [8:0] KBPS_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] KBPS_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
        9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] KBPS_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [8:0] KBPS_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
        9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    typedef struct packed {
        logic              valid_res;
        logic              layer1;
        logic              pad;
        logic [NUM_W-1:0]  num;
        logic [15:0]       rate;
        logic [8:0]        kbps;
        logic [10:0]       spf;
    } item_t;

    function automatic logic [8:0] kbps_lookup(logic [1:0] ver, logic [1:0] lay,
                                               logic [3:0] bri);
        logic [8:0] k;
        if (ver == VER_1) begin
            if (lay == LAY_1) begin
                k = KBPS_V1_L1[bri];
            end else if (lay == LAY_2) begin
                k = KBPS_V1_L2[bri];
            end else begin
                k = KBPS_V1_L3[bri];
            end
        end else if (lay == LAY_1) begin
            k = KBPS_V2_L1[bri];
        end else begin
            k = KBPS_V2_L23[bri];
        end
        return k;
    endfunction

    function automatic logic [15:0] rate_lookup(logic [1:0] ver, logic [1:0] sri);
        logic [15:0] r;
        r = 16'd0;
        unique case (ver)
            VER_25: begin
                unique case (sri)
                    2'd0:    r = 16'd11025;
                    2'd1:    r = 16'd12000;
                    2'd2:    r = 16'd8000;
                    default: r = 16'd0;
                endcase
            end
            VER_2: begin
                unique case (sri)
                    2'd0:    r = 16'd22050;
                    2'd1:    r = 16'd24000;
                    2'd2:    r = 16'd16000;
                    default: r = 16'd0;
                endcase
            end
            VER_1: begin
                unique case (sri)
                    2'd0:    r = 16'd44100;
                    2'd1:    r = 16'd48000;
                    2'd2:    r = 16'd32000;
                    default: r = 16'd0;
                endcase
            end
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/mafl_front.sv =====
// Front end: accepts header items, decodes and checks the fields, forms the numerator.
module mafl_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // header_word
    output logic                 q_valid,
    input  logic                 q_ready,
    output mafl_pkg::item_t      q_item
);
    import mafl_pkg::*;

    typedef struct packed {
        logic        valid_res;
        logic        layer1;
        logic        pad;
        logic [17:0] factor;
        logic [15:0] rate;
        logic [8:0]  kbps;
        logic [10:0] spf;
    } front_t;

    front_t      dec;
    front_t      f_reg;
    logic        f_vld_reg;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic [8:0]  kbps;
    logic [15:0] rate;
    logic        ok;
    logic [26:0] prod;
    logic        accept;

    always_comb begin
        ver  = s_tdata[20:19];
        lay  = s_tdata[18:17];
        bri  = s_tdata[15:12];
        sri  = s_tdata[11:10];
        kbps = kbps_lookup(ver, lay, bri);
        rate = rate_lookup(ver, sri);
        ok   = ((s_tdata & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSV) &&
               (lay != LAY_RSV) && (kbps != 9'd0) && (rate != 16'd0);
        dec  = '0;
        if (ok) begin
            dec.valid_res = 1'b1;
            dec.layer1    = (lay == LAY_1);
            dec.pad       = s_tdata[9];
            dec.rate      = rate;
            dec.kbps      = kbps;
            if (lay == LAY_1) begin
                dec.spf    = SPF_384;
                dec.factor = FACTOR_L1;
            end else if ((lay == LAY_2) || (ver == VER_1)) begin
                dec.spf    = SPF_1152;
                dec.factor = FACTOR_1152;
            end else begin
                dec.spf    = SPF_576;
                dec.factor = FACTOR_576;
            end
        end
    end

    assign s_tready = !f_vld_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    assign prod = {18'd0, f_reg.kbps} * {9'd0, f_reg.factor};

    always_comb begin
        q_valid          = f_vld_reg;
        q_item.valid_res = f_reg.valid_res;
        q_item.layer1    = f_reg.layer1;
        q_item.pad       = f_reg.pad;
        q_item.num       = prod[NUM_W-1:0];
        q_item.rate      = f_reg.rate;
        q_item.kbps      = f_reg.kbps;
        q_item.spf       = f_reg.spf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else begin
            if (accept) begin
                f_vld_reg <= 1'b1;
                f_reg     <= dec;
            end else if (q_ready) begin
                f_vld_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/mafl_queue.sv =====
// Two-entry queue that decouples the decoding front end from the divider back end.
module mafl_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mafl_pkg::item_t  in_item,
    output logic             out_valid,
    input  logic             out_pop,
    output mafl_pkg::item_t  out_item
);
    import mafl_pkg::*;

    item_t      ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = ent_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                ent_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg          <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/mafl_back.sv =====
// Back end: stallable radix-2 divider, 3 quotient bits per cycle, length format, output register.
module mafl_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  mafl_pkg::item_t             q_item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mafl_pkg::OUT_W-1:0]  m_tdata
);
    import mafl_pkg::*;

    item_t            cur_reg;
    logic             busy_reg;
    logic [1:0]       cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [QUO_W-1:0] qn_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    logic             out_free;
    logic             last;
    logic             step;
    logic             finish;
    logic             load;
    logic [REM_W-1:0] rem_next;
    logic [QUO_W-1:0] qn_next;
    logic [REM_W:0]   trial;
    logic [11:0]      sum;
    logic [10:0]      len;
    logic [OUT_W-1:0] res;

    assign out_free = !m_tvalid_reg || m_tready;
    assign last     = (cnt_reg == 2'd3);
    assign step     = busy_reg && (!last || out_free);
    assign finish   = step && last;
    assign load     = (!busy_reg || finish) && q_valid;
    assign q_pop    = load;

    always_comb begin
        rem_next = rem_reg;
        qn_next  = qn_reg;
        trial    = '0;
        for (int i = 0; i < 3; i++) begin
            trial   = {rem_next, qn_next[QUO_W-1]};
            qn_next = {qn_next[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, cur_reg.rate}) begin
                trial      = trial - {1'b0, cur_reg.rate};
                qn_next[0] = 1'b1;
            end
            rem_next = trial[REM_W-1:0];
        end
    end

    always_comb begin
        sum = {1'b0, qn_next[10:0]} + {11'd0, cur_reg.pad};
        if (!cur_reg.valid_res) begin
            len = 11'd0;
        end else if (cur_reg.layer1) begin
            len = {sum[8:0], 2'b00};
        end else begin
            len = sum[10:0];
        end
        res = {cur_reg.spf, cur_reg.rate, cur_reg.kbps, len, cur_reg.valid_res};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (finish) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= res;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (load) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
                rem_reg  <= {2'b00, q_item.num[NUM_W-1:QUO_W]};
                qn_reg   <= q_item.num[QUO_W-1:0];
                cur_reg  <= q_item;
            end else begin
                if (step) begin
                    rem_reg <= rem_next;
                    qn_reg  <= qn_next;
                    cnt_reg <= cnt_reg + 2'd1;
                end
                if (finish) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== src/mpeg_audio_frame_length.sv =====
// Top level of the MPEG audio frame header decoder that reports the frame length.
// Path: front register, queue, divider steps, output register. The divider takes a new
// item only when idle or finishing the last one, retiring 3 quotient bits per cycle over
// 12 bits unless stalled; front end and queue accept an item every cycle until full.
// Reset: synchronous active-low aresetn empties the front register, queue and divider
// and drops m_tvalid; there is no stored state beyond the items in flight.
module mpeg_audio_frame_length (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // header_word
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // valid_res, frame_bytes, bitrate_kbps, sample_rate_hz, samples_per_frame
    output logic [mafl_pkg::OUT_W-1:0]  m_tdata
);
    import mafl_pkg::*;

    logic  fq_valid;
    logic  fq_ready;
    item_t fq_item;
    logic  qb_valid;
    logic  qb_pop;
    item_t qb_item;

    mafl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    mafl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_item  (qb_item)
    );

    mafl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_pop    (qb_pop),
        .q_item   (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/mafl_checker.sv =====
// Port-level checker for the frame length block, bound to the top level.
module mafl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
    endproperty
    a_hold: assert property (p_hold) else $error("result item changed while stalled");

    property p_reset_idle;
        @(posedge aclk) !aresetn |=> !m_tvalid;
    endproperty
    a_reset_idle: assert property (p_reset_idle) else $error("result item after reset");

    property p_invalid_zero;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && !m_tdata[0]) |-> (m_tdata[47:1] == 47'd0);
    endproperty
    a_invalid_zero: assert property (p_invalid_zero)
        else $error("invalid result item carries nonzero fields");

    property p_valid_spf;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[0]) |->
                ((m_tdata[47:37] == 11'd384) || (m_tdata[47:37] == 11'd576) ||
                 (m_tdata[47:37] == 11'd1152));
    endproperty
    a_valid_spf: assert property (p_valid_spf) else $error("bad samples per frame");

    property p_valid_nonzero;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[0]) |->
                ((m_tdata[11:1] != 11'd0) && (m_tdata[20:12] != 9'd0) &&
                 (m_tdata[36:21] != 16'd0));
    endproperty
    a_valid_nonzero: assert property (p_valid_nonzero)
        else $error("valid result item with a zero field");

endmodule

bind mpeg_audio_frame_length mafl_checker u_mafl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the MPEG audio frame length block.
`timescale 1ns / 1ps

module tb;
    import mafl_pkg::*;

    localparam logic [1:0] SRI_RSV = 2'd3;
    localparam logic [3:0] BRI_FREE = 4'd0;
    localparam logic [3:0] BRI_BAD = 4'd15;
    localparam int unsigned L1_NUM = 12000;
    localparam int unsigned L23_NUM = 125;

    // Rows: MPEG-1 layer I, II, III, then lower versions layer I, then layers II and III.
    localparam int unsigned BITRATE [5][16] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    };
    localparam int unsigned SRATE [4][3] = '{
        '{11025, 12000, 8000},
        '{0, 0, 0},
        '{22050, 24000, 16000},
        '{44100, 48000, 32000}
    };
    localparam logic [1:0] VERSIONS [3] = '{VER_25, VER_2, VER_1};
    localparam logic [1:0] LAYERS [3] = '{LAY_3, LAY_2, LAY_1};

    typedef struct packed {
        logic [10:0] spf;
        logic [15:0] rate;
        logic [8:0]  kbps;
        logic [10:0] bytes;
        logic        ok;
    } frame_info_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = 32'd0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;

    logic [31:0]         pending_hdrs [$];
    frame_info_t         expected_frames [$];
    int                  src_idle_pct = 0;
    int                  snk_stall_pct = 0;
    bit                  src_hold = 1'b0;
    int                  accepted_cnt = 0;
    int                  fails = 0;
    frame_info_t         got, want;

    mpeg_audio_frame_length dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic frame_info_t predict_frame(logic [31:0] hdr);
        frame_info_t r;
        logic [1:0] ver, lay, sri;
        logic [3:0] bri;
        int unsigned row, kbps, rate, spf, len, pad;
        r = '0;
        ver = hdr[20:19];
        lay = hdr[18:17];
        bri = hdr[15:12];
        sri = hdr[11:10];
        pad = hdr[9];
        if ((hdr & SYNC_MASK) != SYNC_MASK || ver == VER_RSV || lay == LAY_RSV) begin
            return r;
        end
        if (ver == VER_1) begin
            row = (lay == LAY_1) ? 0 : (lay == LAY_2) ? 1 : 2;
        end else begin
            row = (lay == LAY_1) ? 3 : 4;
        end
        kbps = BITRATE[row][bri];
        rate = (sri == SRI_RSV) ? 0 : SRATE[ver][sri];
        if (kbps == 0 || rate == 0) begin
            return r;
        end
        if (lay == LAY_1) begin
            spf = SPF_384;
        end else if (lay == LAY_2 || ver == VER_1) begin
            spf = SPF_1152;
        end else begin
            spf = SPF_576;
        end
        if (lay == LAY_1) begin
            len = ((L1_NUM * kbps) / rate + pad) * 4;
        end else begin
            len = (L23_NUM * kbps * spf) / rate + pad;
        end
        r.ok = 1'b1;
        r.bytes = len[10:0];
        r.kbps = kbps[8:0];
        r.rate = rate[15:0];
        r.spf = spf[10:0];
        return r;
    endfunction

    function automatic logic [31:0] make_header(logic [1:0] ver, logic [1:0] lay,
                                                logic [3:0] bri, logic [1:0] sri, logic pad);
        logic prot;
        logic [8:0] tail;
        prot = 1'($urandom_range(1));
        tail = 9'($urandom);
        return {11'h7FF, ver, lay, prot, bri, sri, pad, tail};
    endfunction

    function automatic logic [31:0] random_header();
        logic [31:0] h;
        int pick;
        pick = $urandom_range(99);
        h = make_header(VERSIONS[$urandom_range(2)], LAYERS[$urandom_range(2)],
                        4'($urandom_range(14, 1)), 2'($urandom_range(2)), 1'($urandom_range(1)));
        if (pick < 10) begin
            h = $urandom;
        end else if (pick < 20) begin
            case ($urandom_range(4))
                0: h[31 - $urandom_range(10)] = 1'b0;
                1: h[20:19] = VER_RSV;
                2: h[18:17] = LAY_RSV;
                3: h[15:12] = $urandom_range(1) ? BRI_FREE : BRI_BAD;
                default: h[11:10] = SRI_RSV;
            endcase
        end
        return h;
    endfunction

    task automatic wait_drained();
        while (pending_hdrs.size() != 0 || expected_frames.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Driver: an item leaves the pending queue when it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_frames.push_back(predict_frame(pending_hdrs.pop_front()));
                accepted_cnt++;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (pending_hdrs.size() != 0 && !src_hold &&
                         $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_hdrs[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = frame_info_t'(m_tdata);
                if (expected_frames.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    fails++;
                end else begin
                    want = expected_frames.pop_front();
                    if (got.ok !== want.ok) begin
                        $error("valid_res: expected %0d, got %0d", want.ok, got.ok);
                        fails++;
                    end
                    if (got.bytes !== want.bytes) begin
                        $error("frame_bytes: expected %0d, got %0d", want.bytes, got.bytes);
                        fails++;
                    end
                    if (got.kbps !== want.kbps) begin
                        $error("bitrate_kbps: expected %0d, got %0d", want.kbps, got.kbps);
                        fails++;
                    end
                    if (got.rate !== want.rate) begin
                        $error("sample_rate_hz: expected %0d, got %0d", want.rate, got.rate);
                        fails++;
                    end
                    if (got.spf !== want.spf) begin
                        $error("samples_per_frame: expected %0d, got %0d", want.spf, got.spf);
                        fails++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        int src_pcts [4];
        int snk_pcts [4];
        int target;
        src_pcts = '{0, 57, 0, 26};
        snk_pcts = '{0, 0, 57, 26};
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        pending_hdrs.push_back(32'h0000_0000);
        pending_hdrs.push_back(32'hFFFF_FFFF);
        for (int vi = 0; vi < 3; vi++) begin
            for (int li = 0; li < 3; li++) begin
                pending_hdrs.push_back(make_header(VERSIONS[vi], LAYERS[li],
                    4'(1 + ((vi * 3 + li) * 5) % 14), 2'(li), 1'(vi)));
            end
        end
        // Largest frames of layers II and I, and a lowest-bitrate MPEG-2.5 layer III frame.
        pending_hdrs.push_back(make_header(VER_1, LAY_2, 4'd14, 2'd2, 1'b1));
        pending_hdrs.push_back(make_header(VER_1, LAY_1, 4'd14, 2'd2, 1'b1));
        pending_hdrs.push_back(make_header(VER_25, LAY_3, 4'd1, 2'd2, 1'b0));
        pending_hdrs.push_back(make_header(VER_1, LAY_3, 4'd9, 2'd0, 1'b1) & ~32'h0020_0000);
        pending_hdrs.push_back(make_header(VER_1, LAY_3, 4'd9, 2'd0, 1'b1) & ~32'h8000_0000);
        pending_hdrs.push_back(make_header(VER_RSV, LAY_3, 4'd5, 2'd1, 1'b0));
        pending_hdrs.push_back(make_header(VER_2, LAY_RSV, 4'd5, 2'd1, 1'b0));
        pending_hdrs.push_back(make_header(VER_1, LAY_2, BRI_FREE, 2'd1, 1'b0));
        pending_hdrs.push_back(make_header(VER_2, LAY_1, BRI_BAD, 2'd1, 1'b1));
        pending_hdrs.push_back(make_header(VER_25, LAY_2, 4'd7, SRI_RSV, 1'b1));
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_pcts[p];
            snk_stall_pct = snk_pcts[p];
            target = accepted_cnt + 47;
            repeat (95) pending_hdrs.push_back(random_header());
            while (accepted_cnt < target) begin
                @(posedge aclk);
            end
            // The sender holds back until the block has delivered everything.
            src_hold = 1'b1;
            while (expected_frames.size() != 0 || s_tvalid) begin
                @(posedge aclk);
            end
            src_hold = 1'b0;
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
